// ----- hw/rtl/cbrm_pkg.sv -----
// Shared types and constants of the channel busy ratio meter.
// No dependencies; every other RTL file except cbrm_ram imports this package.
`default_nettype none
package cbrm_pkg;

    localparam int TIME_BITS   = 40;
    localparam int PERIOD_BITS = 10;
    localparam int WIN_BITS    = 16;
    localparam int RUN_BITS    = 16;
    localparam int CBR_BITS    = 17;
    localparam int HELD_BITS   = 7;
    localparam int DIV_W       = TIME_BITS;

    localparam logic [PERIOD_BITS-1:0] PERIOD_RESET = 10'd8;
    localparam logic [WIN_BITS-1:0]    WINDOW_RESET = 16'd12500;

    // configuration register indexes
    localparam logic CFG_SAMPLE_PERIOD = 1'b0;
    localparam logic CFG_WINDOW        = 1'b1;

    typedef struct packed {
        logic [TIME_BITS-1:0] now_us;
        logic                 busy_flag;
        logic                 clear;
    } t_in_item;

    typedef struct packed {
        logic [WIN_BITS-1:0]  busy_samples;
        logic [CBR_BITS-1:0]  cbr_q16;
        logic [HELD_BITS-1:0] runs_held;
        logic                 run_dropped;
    } t_out_item;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_TDIV_GO,
        ST_TDIV_WAIT,
        ST_UPDATE,
        ST_WALK_GO,
        ST_WALK,
        ST_RDIV_GO,
        ST_RDIV_WAIT,
        ST_DONE
    } t_state;

    typedef struct packed {
        logic latch;
        logic tdiv_go;
        logic rdiv_go;
        logic update;
        logic walk_go;
        logic walk_step;
        logic load_out;
    } t_cmd;

    typedef struct packed {
        logic div_done;
        logic runs_empty;
        logic walk_end;
        logic out_free;
    } t_sts;

endpackage
`default_nettype wire

// ----- hw/rtl/cbrm_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`default_nettype none
module cbrm_ram #(
    parameter int WIDTH = 17,
    parameter int DEPTH = 64
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output      logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end
endmodule
`default_nettype wire

// ----- hw/rtl/cbrm_div.sv -----
// Restoring serial divider, one quotient bit per cycle.
// Imports cbrm_pkg but uses nothing from it; used by the datapath.
`default_nettype none
module cbrm_div
    import cbrm_pkg::*;
#(
    parameter int DW = 40,
    parameter int VW = 16
) (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_start,
    input  wire logic [DW-1:0] i_dividend,
    input  wire logic [VW-1:0] i_divisor,
    output      logic          o_done,
    output      logic [DW-1:0] o_quotient
);
    localparam int CNW = $clog2(DW + 1);

    logic [DW-1:0]  r_quo;
    logic [VW-1:0]  r_rem;
    logic [VW-1:0]  r_div;
    logic [CNW-1:0] r_cnt;
    logic           r_run;
    logic           r_done;
    logic [VW:0]    rem_sh;
    logic [VW:0]    diff;
    logic           ge;

    assign rem_sh = {r_rem, r_quo[DW-1]};
    assign diff   = rem_sh - {1'b0, r_div};
    assign ge     = rem_sh >= {1'b0, r_div};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_run  <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_run <= 1'b1;
                r_cnt <= CNW'(DW);
            end else if (r_run) begin
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == CNW'(1)) begin
                    r_run  <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_quo <= i_dividend;
            r_rem <= '0;
            r_div <= i_divisor;
        end else if (r_run) begin
            r_rem <= ge ? diff[VW-1:0] : rem_sh[VW-1:0];
            r_quo <= {r_quo[DW-2:0], ge};
        end
    end

    assign o_done     = r_done;
    assign o_quotient = r_quo;
endmodule
`default_nettype wire

// ----- hw/rtl/cbrm_datapath.sv -----
// Datapath: configuration, timing state, run store walk, divider, result register.
// Depends on cbrm_pkg, cbrm_ram and cbrm_div.
`default_nettype none
module cbrm_datapath
    import cbrm_pkg::*;
#(
    parameter int MAX_RUNS = 64
) (
    input  wire logic                   i_clk,
    input  wire logic                   i_rst_n,
    input  wire logic                   i_cfg_we,
    input  wire logic                   i_cfg_idx,
    input  wire logic [WIN_BITS-1:0]    i_cfg_data,
    input  wire t_in_item               i_in_data,
    input  wire t_cmd                   i_cmd,
    output      t_sts                   o_sts,
    output      logic                   o_out_valid,
    input  wire logic                   i_out_stall,
    output      t_out_item              o_out_data
);
    localparam int CW = $clog2(MAX_RUNS + 1);
    localparam int SW = $clog2(MAX_RUNS);

    logic [PERIOD_BITS-1:0] r_period;
    logic [WIN_BITS-1:0]    r_window;
    logic [TIME_BITS-1:0]   r_last, n_last;
    logic                   r_line_busy, n_line_busy;
    logic [CW-1:0]          r_count, n_count;
    logic [SW-1:0]          r_newest, n_newest;
    t_in_item               r_item;
    logic [WIN_BITS-1:0]    r_total, n_total;
    logic [WIN_BITS-1:0]    r_busy, n_busy;
    logic                   r_dropped, n_dropped;
    logic [CW-1:0]          r_idx, n_idx;
    logic [SW-1:0]          r_rd_slot, n_rd_slot;
    logic [SW-1:0]          r_cur_slot, n_cur_slot;
    t_out_item              r_out;
    logic                   r_out_valid;

    logic [WIN_BITS-1:0]    win;
    logic [WIN_BITS-1:0]    period;
    logic [TIME_BITS-1:0]   elapsed;
    logic [DIV_W-1:0]       div_dividend;
    logic [WIN_BITS-1:0]    div_divisor;
    logic                   div_done;
    logic [DIV_W-1:0]       quo;
    logic [TIME_BITS-1:0]   pend_after;
    logic [SW-1:0]          push_slot;
    logic [RUN_BITS:0]      rd_data;
    logic [RUN_BITS-1:0]    rd_len;
    logic                   rd_busy;
    logic [WIN_BITS:0]      sum;
    logic                   brk;
    logic [WIN_BITS-1:0]    in_part;
    logic                   ram_we;
    logic [SW-1:0]          ram_waddr;
    logic [RUN_BITS:0]      ram_wdata;
    logic [SW-1:0]          ram_raddr;
    logic                   out_free;

    assign win    = (r_window == '0) ? WIN_BITS'(1) : r_window;
    assign period = (r_period == '0) ? WIN_BITS'(1) : WIN_BITS'(r_period);

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_period <= PERIOD_RESET;
            r_window <= WINDOW_RESET;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_SAMPLE_PERIOD: r_period <= i_cfg_data[PERIOD_BITS-1:0];
                CFG_WINDOW:        r_window <= i_cfg_data;
                default:           r_window <= r_window;
            endcase
        end
    end

    assign elapsed = (r_item.now_us >= r_last) ? (r_item.now_us - r_last) : '0;

    // shared divider: elapsed / period, then busy * 2^16 / window
    assign div_dividend = i_cmd.rdiv_go ? DIV_W'({r_busy, 16'h0000}) : DIV_W'(elapsed);
    assign div_divisor  = i_cmd.rdiv_go ? win : period;

    cbrm_div #(.DW(DIV_W), .VW(WIN_BITS)) u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (i_cmd.tdiv_go | i_cmd.rdiv_go),
        .i_dividend (div_dividend),
        .i_divisor  (div_divisor),
        .o_done     (div_done),
        .o_quotient (quo)
    );

    assign push_slot = (r_newest == SW'(MAX_RUNS - 1)) ? '0 : r_newest + 1'b1;

    assign rd_len  = rd_data[RUN_BITS:1];
    assign rd_busy = rd_data[0];
    assign sum     = {1'b0, r_total} + {1'b0, rd_len};
    assign brk     = sum >= {1'b0, win};
    assign in_part = (r_total < win) ? win - r_total : '0;

    always_comb begin
        n_last      = r_last;
        n_line_busy = r_line_busy;
        n_count     = r_count;
        n_newest    = r_newest;
        n_total     = r_total;
        n_busy      = r_busy;
        n_dropped   = r_dropped;
        n_idx       = r_idx;
        n_rd_slot   = r_rd_slot;
        n_cur_slot  = r_cur_slot;
        pend_after  = '0;
        ram_we      = 1'b0;
        ram_waddr   = push_slot;
        ram_wdata   = {(|quo[DIV_W-1:RUN_BITS]) ? {RUN_BITS{1'b1}} : quo[RUN_BITS-1:0],
                       r_line_busy};
        ram_raddr   = r_newest;

        if (i_cmd.update) begin
            n_dropped = 1'b0;
            if (r_item.clear) begin
                n_count     = '0;
                n_line_busy = 1'b0;
                n_last      = r_item.now_us;
            end else if (r_item.busy_flag != r_line_busy) begin
                // close the run that just ended, if it spans a whole period
                if (quo != '0) begin
                    ram_we   = 1'b1;
                    n_newest = push_slot;
                    if (r_count < CW'(MAX_RUNS)) begin
                        n_count = r_count + 1'b1;
                    end else begin
                        n_dropped = 1'b1;
                    end
                end
                n_line_busy = r_item.busy_flag;
                n_last      = r_item.now_us;
            end else begin
                pend_after = quo;
            end
            n_total = (pend_after >= TIME_BITS'(win)) ? win : pend_after[WIN_BITS-1:0];
            n_busy  = n_line_busy ? n_total : '0;
        end

        if (i_cmd.walk_go) begin
            n_idx      = '0;
            n_cur_slot = r_newest;
            n_rd_slot  = (r_newest == '0) ? SW'(MAX_RUNS - 1) : r_newest - 1'b1;
        end

        if (i_cmd.walk_step) begin
            ram_raddr = r_rd_slot;
            if (brk) begin
                if (rd_busy) begin
                    n_busy = r_busy + in_part;
                end
                // keep only the part of the edge run inside the window
                if (in_part != '0) begin
                    ram_we    = 1'b1;
                    ram_waddr = r_cur_slot;
                    ram_wdata = {in_part, rd_busy};
                    n_count   = r_idx + 1'b1;
                end else begin
                    n_count = r_idx;
                end
            end else begin
                n_total = sum[WIN_BITS-1:0];
                if (rd_busy) begin
                    n_busy = r_busy + rd_len;
                end
                n_idx      = r_idx + 1'b1;
                n_cur_slot = r_rd_slot;
                n_rd_slot  = (r_rd_slot == '0) ? SW'(MAX_RUNS - 1) : r_rd_slot - 1'b1;
            end
        end
    end

    cbrm_ram #(.WIDTH(RUN_BITS + 1), .DEPTH(MAX_RUNS)) u_runs (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_raddr (ram_raddr),
        .o_rdata (rd_data)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_last      <= '0;
            r_line_busy <= 1'b0;
            r_count     <= '0;
            r_newest    <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_last      <= n_last;
            r_line_busy <= n_line_busy;
            r_count     <= n_count;
            r_newest    <= n_newest;
            if (i_cmd.load_out) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.latch) begin
            r_item <= i_in_data;
        end
        r_total    <= n_total;
        r_busy     <= n_busy;
        r_dropped  <= n_dropped;
        r_idx      <= n_idx;
        r_rd_slot  <= n_rd_slot;
        r_cur_slot <= n_cur_slot;
        if (i_cmd.load_out) begin
            r_out.busy_samples <= r_busy;
            r_out.cbr_q16      <= quo[CBR_BITS-1:0];
            r_out.runs_held    <= HELD_BITS'(r_count);
            r_out.run_dropped  <= r_dropped;
        end
    end

    assign out_free = !r_out_valid || !i_out_stall;

    assign o_sts.div_done   = div_done;
    assign o_sts.runs_empty = (r_count == '0);
    assign o_sts.walk_end   = brk || ((CW + 1)'(r_idx) + 1'b1 == (CW + 1)'(r_count));
    assign o_sts.out_free   = out_free;

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;
endmodule
`default_nettype wire

// ----- hw/rtl/cbrm_ctrl.sv -----
// Controller state machine that sequences one item through the datapath.
// Depends on cbrm_pkg.
`default_nettype none
module cbrm_ctrl
    import cbrm_pkg::*;
(
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire logic i_in_valid,
    output      logic o_in_stall,
    input  wire t_sts i_sts,
    output      t_cmd o_cmd
);
    t_state r_state, n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state    = r_state;
        o_cmd      = '0;
        o_in_stall = 1'b1;
        unique case (r_state)
            ST_IDLE: begin
                o_in_stall = 1'b0;
                if (i_in_valid) begin
                    o_cmd.latch = 1'b1;
                    n_state     = ST_TDIV_GO;
                end
            end
            ST_TDIV_GO: begin
                o_cmd.tdiv_go = 1'b1;
                n_state       = ST_TDIV_WAIT;
            end
            ST_TDIV_WAIT: begin
                if (i_sts.div_done) begin
                    n_state = ST_UPDATE;
                end
            end
            ST_UPDATE: begin
                o_cmd.update = 1'b1;
                n_state      = ST_WALK_GO;
            end
            ST_WALK_GO: begin
                if (i_sts.runs_empty) begin
                    n_state = ST_RDIV_GO;
                end else begin
                    o_cmd.walk_go = 1'b1;
                    n_state       = ST_WALK;
                end
            end
            ST_WALK: begin
                o_cmd.walk_step = 1'b1;
                if (i_sts.walk_end) begin
                    n_state = ST_RDIV_GO;
                end
            end
            ST_RDIV_GO: begin
                o_cmd.rdiv_go = 1'b1;
                n_state       = ST_RDIV_WAIT;
            end
            ST_RDIV_WAIT: begin
                if (i_sts.div_done) begin
                    n_state = ST_DONE;
                end
            end
            ST_DONE: begin
                if (i_sts.out_free) begin
                    o_cmd.load_out = 1'b1;
                    n_state        = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end
endmodule
`default_nettype wire

// ----- hw/rtl/channel_busy_ratio_meter_unit.sv -----
// Top level of the channel busy ratio meter.
// Depends on cbrm_pkg, cbrm_ctrl and cbrm_datapath (with cbrm_div, cbrm_ram).
//
// Usage:
//   Input beats (i_in_valid / o_in_stall) carry now_us, busy_flag and clear.
//   Each input beat yields exactly one output beat (o_out_valid / i_out_stall)
//   with busy samples in the window, the Q16 busy ratio, the runs still held
//   and a flag for a run pushed out of a full store.
//   Configuration: pulse i_cfg_we with i_cfg_idx 0 (sample period, 10 bits)
//   or 1 (window length, 16 bits); write only while the block is idle.
// Sequence:
//   One item at a time. An item passes through a serial division for the
//   elapsed periods, a walk over the stored runs (if any, up to MAX_RUNS),
//   one run per cycle, and a second serial division for the ratio, all on
//   the one shared divider. The next input beat is accepted as soon as the
//   result sits in the output register, even while the receiver stalls it;
//   a result waiting in that register holds the following item at its end
//   until the register drains.
// Reset:
//   Synchronous, active low: idle line, no runs, time base zero, period 8 us,
//   window 12500 periods. The run RAM needs no clearing pass.
`default_nettype none
module channel_busy_ratio_meter_unit
    import cbrm_pkg::*;
#(
    parameter int MAX_RUNS = 64
) (
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire logic                i_cfg_we,
    input  wire logic                i_cfg_idx,
    input  wire logic [WIN_BITS-1:0] i_cfg_data,
    input  wire logic                i_in_valid,
    output      logic                o_in_stall,
    input  wire t_in_item            i_in_data,
    output      logic                o_out_valid,
    input  wire logic                i_out_stall,
    output      t_out_item           o_out_data
);
    t_cmd cmd;
    t_sts sts;

    // sequence: latch, divide elapsed time, update runs, walk, divide ratio, hold result
    cbrm_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_stall (o_in_stall),
        .i_sts      (sts),
        .o_cmd      (cmd)
    );

    cbrm_datapath #(.MAX_RUNS(MAX_RUNS)) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_idx   (i_cfg_idx),
        .i_cfg_data  (i_cfg_data),
        .i_in_data   (i_in_data),
        .i_cmd       (cmd),
        .o_sts       (sts),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_data  (o_out_data)
    );

    // one item in flight: after an accepted beat, stall until the result is out
    a_one_in_flight: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && !o_in_stall) |=> o_in_stall)
        else $error("input accepted while an item is in flight");

    // never overwrite a result the receiver has not taken
    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cmd.load_out |-> sts.out_free)
        else $error("result register overwritten");

    // a ratio needs busy samples
    a_ratio_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_out_data.busy_samples == '0) |-> (o_out_data.cbr_q16 == '0))
        else $error("nonzero ratio with zero busy samples");
endmodule
`default_nettype wire

// ----- sim/tb_top.sv -----
// Testbench for channel_busy_ratio_meter_unit: random and directed busy/idle beats
// checked against an in-bench model of the sliding-window busy ratio.
// Depends on cbrm_pkg and the RTL of the meter.
module tb_top;
    import cbrm_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int RUNS = 64;

    logic                i_clk = 1'b0;
    logic                i_rst_n = 1'b0;
    logic                cfg_we = 1'b0;
    logic                cfg_idx = CFG_SAMPLE_PERIOD;
    logic [WIN_BITS-1:0] cfg_data = '0;
    logic                in_valid = 1'b0;
    logic                in_stall;
    t_in_item            in_data = '0;
    logic                out_valid;
    logic                out_stall = 1'b0;
    t_out_item           out_data;

    channel_busy_ratio_meter_unit #(.MAX_RUNS(RUNS)) i_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (cfg_we),
        .i_cfg_idx   (cfg_idx),
        .i_cfg_data  (cfg_data),
        .i_in_valid  (in_valid),
        .o_in_stall  (in_stall),
        .i_in_data   (in_data),
        .o_out_valid (out_valid),
        .i_out_stall (out_stall),
        .o_out_data  (out_data)
    );

    always #2 i_clk = ~i_clk;

    // Model state: configuration, timing base and the ring of stored runs.
    logic [PERIOD_BITS-1:0] m_period;
    logic [WIN_BITS-1:0]    m_window;
    logic [TIME_BITS-1:0]   m_last_change;
    logic                   m_line_busy;
    logic [RUN_BITS-1:0]    m_run_len [RUNS];
    logic                   m_run_busy [RUNS];
    int unsigned            m_run_count;
    int unsigned            m_newest;

    t_out_item   ratio_queue[$];
    int          fail_count = 0;
    int          send_idle_pct = 0;
    int          recv_idle_pct = 0;
    bit          recv_hold = 1'b0;
    logic [TIME_BITS-1:0] clock_us = '0;

    function automatic longint unsigned elapsed_periods(logic [TIME_BITS-1:0] now);
        longint unsigned per;
        per = (m_period == 0) ? 1 : m_period;
        if (now < m_last_change) return 0;
        return (now - m_last_change) / per;
    endfunction

    // Advance the model by one beat and return the report it produces.
    function automatic t_out_item predict_ratio(t_in_item item);
        t_out_item       r;
        longint unsigned pend;
        longint unsigned win;
        longint unsigned total;
        longint unsigned busy;
        longint unsigned len;
        longint unsigned prior;
        longint unsigned part;
        int unsigned     s;
        bit              dropped;
        dropped = 1'b0;
        total = 0;
        busy = 0;
        win = (m_window == 0) ? 1 : m_window;
        if (item.clear) begin
            m_run_count = 0;
            m_line_busy = 1'b0;
            m_last_change = item.now_us;
        end else if (item.busy_flag != m_line_busy) begin
            pend = elapsed_periods(item.now_us);
            if (pend > 0) begin
                m_newest = (m_newest + 1) % RUNS;
                m_run_len[m_newest] = (pend > 65535) ? 16'hFFFF : pend[15:0];
                m_run_busy[m_newest] = m_line_busy;
                if (m_run_count < RUNS) m_run_count++;
                else dropped = 1'b1;
            end
            m_line_busy = item.busy_flag;
            m_last_change = item.now_us;
        end
        pend = elapsed_periods(item.now_us);
        if (pend > 0) begin
            total = (pend < win) ? pend : win;
            busy = m_line_busy ? total : 0;
        end
        for (int unsigned i = 0; i < m_run_count; i++) begin
            s = (m_newest + RUNS - i) % RUNS;
            len = m_run_len[s];
            prior = total;
            total += len;
            if (total < win) begin
                if (m_run_busy[s]) busy += len;
            end else begin
                // trim the edge run to its part inside the window
                part = (prior < win) ? win - prior : 0;
                if (m_run_busy[s]) busy += part;
                if (part > 0) begin
                    m_run_len[s] = part[15:0];
                    m_run_count = i + 1;
                end else begin
                    m_run_count = i;
                end
                break;
            end
        end
        if (busy > win) busy = win;
        r.busy_samples = busy[15:0];
        r.cbr_q16 = CBR_BITS'((busy << 16) / win);
        r.runs_held = HELD_BITS'(m_run_count);
        r.run_dropped = dropped;
        return r;
    endfunction

    // Send one beat; the prediction is made when the beat is accepted.
    // Valid stays up after acceptance; idle cycles and waits drop it.
    task automatic send_beat(logic [TIME_BITS-1:0] now, logic busy, logic clr);
        t_in_item item;
        while ($urandom_range(99) < send_idle_pct) begin
            in_valid <= 1'b0;
            @(negedge i_clk);
        end
        item.now_us = now;
        item.busy_flag = busy;
        item.clear = clr;
        in_data <= item;
        in_valid <= 1'b1;
        do @(posedge i_clk); while (in_stall);
        ratio_queue.push_back(predict_ratio(item));
        @(negedge i_clk);
    endtask

    task automatic drain();
        in_valid <= 1'b0;
        while (ratio_queue.size() != 0) @(negedge i_clk);
        repeat (250) @(negedge i_clk);
    endtask

    task automatic write_cfg(logic idx, logic [WIN_BITS-1:0] val);
        drain();
        cfg_we <= 1'b1;
        cfg_idx <= idx;
        cfg_data <= val;
        @(negedge i_clk);
        cfg_we <= 1'b0;
        if (idx == CFG_SAMPLE_PERIOD) m_period = val[PERIOD_BITS-1:0];
        else m_window = val;
    endtask

    // Step time forward by a mostly small amount; sometimes huge or backward.
    task automatic random_beat();
        int unsigned pick;
        logic [TIME_BITS-1:0] step;
        pick = $urandom_range(99);
        if (pick < 70) step = TIME_BITS'($urandom_range(64));
        else if (pick < 90) step = TIME_BITS'($urandom_range(4000));
        else if (pick < 95) step = TIME_BITS'({$urandom(), $urandom()});
        else step = '0;
        if (pick >= 97 && clock_us > 50) clock_us = clock_us - TIME_BITS'($urandom_range(50));
        else clock_us = clock_us + step;
        send_beat(clock_us, ($urandom_range(99) < 85) ? ~m_line_busy : m_line_busy,
                  $urandom_range(99) < 2);
    endtask

    // Compare each result with the oldest waiting expectation.
    always @(posedge i_clk) begin
        t_out_item want;
        if (i_rst_n && out_valid && !out_stall) begin
            if (ratio_queue.size() == 0) begin
                $display("%0t: unexpected result %h", $time, out_data);
                fail_count++;
            end else begin
                want = ratio_queue.pop_front();
                if (out_data.busy_samples !== want.busy_samples ||
                    out_data.cbr_q16 !== want.cbr_q16 ||
                    out_data.runs_held !== want.runs_held ||
                    out_data.run_dropped !== want.run_dropped) begin
                    $display("%0t: expected busy=%0d cbr=%0d held=%0d drop=%0b",
                             $time, want.busy_samples, want.cbr_q16,
                             want.runs_held, want.run_dropped);
                    $display("%0t:   actual busy=%0d cbr=%0d held=%0d drop=%0b",
                             $time, out_data.busy_samples, out_data.cbr_q16,
                             out_data.runs_held, out_data.run_dropped);
                    fail_count++;
                end
            end
        end
    end

    // Receiver stall: random idling, or a long hold when requested.
    always @(negedge i_clk) begin
        out_stall <= recv_hold || ($urandom_range(99) < recv_idle_pct);
    end

    task automatic test_directed();
        send_beat(40'd0, 1'b0, 1'b0);
        send_beat(40'd100, 1'b1, 1'b0);
        send_beat(40'd103, 1'b0, 1'b0);          // short change
        send_beat(40'd90, 1'b1, 1'b0);           // time going back
        send_beat(40'hFF_FFFF_FFFF, 1'b0, 1'b0); // long run saturates
        send_beat(40'hFF_FFFF_FFFF, 1'b1, 1'b1); // clear ignores busy
        send_beat(40'd0, 1'b1, 1'b0);
        write_cfg(CFG_SAMPLE_PERIOD, 16'd0);
        write_cfg(CFG_WINDOW, 16'd0);
        send_beat(40'd5, 1'b0, 1'b0);
        send_beat(40'd9, 1'b1, 1'b0);
        write_cfg(CFG_WINDOW, 16'd20);
        for (int i = 0; i < 6; i++) send_beat(40'd20 + 7 * i, i[0], 1'b0);
        write_cfg(CFG_SAMPLE_PERIOD, 16'd1023);
        write_cfg(CFG_WINDOW, 16'd65535);
        send_beat(40'd5000, 1'b0, 1'b0);
        send_beat(40'd900000, 1'b1, 1'b0);
        send_beat(40'd9000000, 1'b0, 1'b0);
        clock_us = 40'd9000000;
    endtask

    // Many short runs overflow the 64-entry store.
    task automatic test_full_store();
        write_cfg(CFG_SAMPLE_PERIOD, 16'd1);
        write_cfg(CFG_WINDOW, 16'd65535);
        for (int i = 0; i < 80; i++) begin
            clock_us = clock_us + 1 + $urandom_range(3);
            send_beat(clock_us, ~m_line_busy, 1'b0);
        end
    endtask

    task automatic test_random(int n);
        logic [WIN_BITS-1:0] wins [4] = '{16'd1, 16'd50, 16'd3000, 16'd65535};
        for (int k = 0; k < 4; k++) begin
            write_cfg(CFG_SAMPLE_PERIOD, WIN_BITS'($urandom_range(1023)));
            write_cfg(CFG_WINDOW, (k == 3) ? WIN_BITS'($urandom_range(65535)) : wins[k]);
            for (int i = 0; i < n / 4; i++) random_beat();
        end
    endtask

    // Hold the receiver long enough for the block to stall its input.
    task automatic test_backpressure();
        fork
            begin
                recv_hold = 1'b1;
                for (int c = 0; c < 600; c++) @(negedge i_clk);
                recv_hold = 1'b0;
            end
            for (int i = 0; i < 10; i++) random_beat();
        join
        // pause the sender until everything has drained
        in_valid <= 1'b0;
        while (ratio_queue.size() != 0) @(negedge i_clk);
        for (int i = 0; i < 10; i++) random_beat();
    endtask

    initial begin
        m_period = PERIOD_RESET;
        m_window = WINDOW_RESET;
        m_last_change = '0;
        m_line_busy = 1'b0;
        m_run_count = 0;
        m_newest = 0;
        foreach (m_run_len[i]) begin
            m_run_len[i] = '0;
            m_run_busy[i] = 1'b0;
        end
        repeat (9) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);
        test_directed();
        send_idle_pct = 35;
        recv_idle_pct = 72;
        test_full_store();
        test_random(600);
        send_idle_pct = 72;
        recv_idle_pct = 35;
        test_random(600);
        send_idle_pct = 0;
        recv_idle_pct = 0;
        test_backpressure();
        test_random(480);
        drain();
        if (fail_count == 0) $display("== PASS ==");
        else $display("== FAIL ==");
        $finish;
    end

    initial begin
        #20ms;
        $display("== FAIL ==");
        $finish;
    end
endmodule

// ----- filelist.f -----
hw/rtl/cbrm_pkg.sv
hw/rtl/cbrm_ram.sv
hw/rtl/cbrm_div.sv
hw/rtl/cbrm_datapath.sv
hw/rtl/cbrm_ctrl.sv
hw/rtl/channel_busy_ratio_meter_unit.sv
sim/tb_top.sv
